### hdl/qdp_pkg.sv
// qdp_pkg: shared types and constants for the quad distance panner.
// No dependencies; every qdp_* module but qdp_pipe_ctrl imports it.
`default_nettype none

package qdp_pkg;

    localparam int unsigned LANES                = 4;
    localparam int unsigned TABLE_POINTS_DEFAULT = 256;

    localparam int unsigned CORNER_FL = 0;
    localparam int unsigned CORNER_FR = 1;
    localparam int unsigned CORNER_BL = 2;
    localparam int unsigned CORNER_BR = 3;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef logic [16:0] q16_t;
    typedef logic [32:0] half_sq_t;
    typedef q16_t     [LANES-1:0] q16_vec_t;
    typedef half_sq_t [LANES-1:0] half_sq_vec_t;

endpackage

`default_nettype wire

### hdl/quad_distance_panner.sv
// quad_distance_panner: top level of the four-speaker distance panner.
// Depends on qdp_pkg, qdp_pipe_ctrl, qdp_square, qdp_isqrt, qdp_cos_lerp, qdp_norm.
//
// Usage:
//   Slave channel (s_*): one beat carries a pan position, pan_x and pan_y,
//   unsigned Q0.16; values above 1.0 saturate to 1.0.
//   Master channel (m_*): one beat per input beat with the four normalized
//   gains front-left, front-right, back-left, back-right, unsigned Q0.16.
//   Stages from input beat to output beat: 3 squaring, 6 square root,
//   4 table lookup, 8 normalize/divide.
//   Throughput: one beat per cycle while the output is not stalled; the square
//   root and divider are fully pipelined, up to 3 result bits per stage.
//   A stall on m_tready holds the output beat; earlier stages keep filling
//   any empty slots, so s_tready drops only once the pipeline is full.
//   Reset clears all valid bits; the pipeline comes out of reset empty and
//   ready. No configuration, no state kept between beats.
`default_nettype none

module quad_distance_panner #(
    parameter int unsigned TABLE_POINTS = qdp_pkg::TABLE_POINTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pan_x[16:0], pan_y[33:17], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // gain_front_left[16:0], gain_front_right[33:17],
                                   // gain_back_left[50:34], gain_back_right[67:51]
);
    import qdp_pkg::*;

    logic         sq_valid, sq_ready;
    half_sq_vec_t half_sq;
    logic         rt_valid, rt_ready;
    q16_vec_t     dnorm;
    logic         cs_valid, cs_ready;
    q16_vec_t     raw;
    q16_vec_t     gain;

    qdp_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .pan_x    (s_tdata[16:0]),
        .pan_y    (s_tdata[33:17]),
        .out_valid(sq_valid),
        .out_ready(sq_ready),
        .half_sq  (half_sq)
    );

    qdp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sq_valid),
        .in_ready (sq_ready),
        .half_sq  (half_sq),
        .out_valid(rt_valid),
        .out_ready(rt_ready),
        .dnorm    (dnorm)
    );

    qdp_cos_lerp #(.TABLE_POINTS(TABLE_POINTS)) u_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rt_valid),
        .in_ready (rt_ready),
        .dnorm    (dnorm),
        .out_valid(cs_valid),
        .out_ready(cs_ready),
        .gain     (raw)
    );

    qdp_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cs_valid),
        .in_ready (cs_ready),
        .raw      (raw),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .gain     (gain)
    );

    assign m_tdata = {4'h0, gain[CORNER_BR], gain[CORNER_BL],
                      gain[CORNER_FR], gain[CORNER_FL]};

`ifndef NO_ASSERTIONS
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (gain[0] <= ONE_Q16) && (gain[1] <= ONE_Q16) &&
                     (gain[2] <= ONE_Q16) && (gain[3] <= ONE_Q16))
        else $error("gain above unity");
    a_gain_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((19'(gain[0]) + 19'(gain[1]) + 19'(gain[2]) + 19'(gain[3]))
                      >= 19'd65532) &&
                     ((19'(gain[0]) + 19'(gain[1]) + 19'(gain[2]) + 19'(gain[3]))
                      <= 19'd65540))
        else $error("normalized gains do not sum to unity");
    a_one_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones({gain[0] == '0, gain[1] == '0,
                                 gain[2] == '0, gain[3] == '0}) <= 1)
        else $error("more than one silent corner");
`endif

endmodule

`default_nettype wire

### hdl/qdp_pipe_ctrl.sv
// qdp_pipe_ctrl: valid bits and per-stage load enables of a stallable pipeline.
// A stage loads when it is empty or its successor loads. Uses no package.
`default_nettype none

module qdp_pipe_ctrl #(
    parameter int unsigned STAGES = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic [STAGES-1:0] load,
    output logic [STAGES-1:0] valid
);

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] v_in;
    logic [STAGES:0]   en;

    assign en[STAGES] = out_ready;

    for (genvar k = 0; k < STAGES; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign v_in     = {v_reg[STAGES-2:0], in_valid};
    assign load     = en[STAGES-1:0];
    assign v_next   = (load & v_in) | (~load & v_reg);
    assign valid    = v_reg;
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

endmodule

`default_nettype wire

### hdl/qdp_square.sv
// qdp_square: saturates the position and forms floor(d^2/2) for the four corners.
// Depends on qdp_pkg and qdp_pipe_ctrl.
`default_nettype none

module qdp_square (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qdp_pkg::q16_t        pan_x,
    input  qdp_pkg::q16_t        pan_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qdp_pkg::half_sq_vec_t half_sq
);
    import qdp_pkg::*;

    localparam int unsigned NST = 3;

    logic [NST-1:0] load;
    logic [NST-1:0] valid;

    q16_t         x_reg, y_reg, x_next, y_next;
    logic [33:0]  sx_reg, sxo_reg, sy_reg, syo_reg;
    logic [33:0]  sx_next, sxo_next, sy_next, syo_next;
    half_sq_vec_t half_reg, half_next;

    qdp_pipe_ctrl #(.STAGES(NST)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_ready(out_ready),
        .load     (load),
        .valid    (valid)
    );

    always_comb
    begin
        logic [34:0] s_fl, s_fr, s_bl, s_br;
        q16_t        ox, oy;
        x_next   = (pan_x > ONE_Q16) ? ONE_Q16 : pan_x;
        y_next   = (pan_y > ONE_Q16) ? ONE_Q16 : pan_y;
        ox       = ONE_Q16 - x_reg;
        oy       = ONE_Q16 - y_reg;
        sx_next  = 34'(x_reg) * 34'(x_reg);
        sxo_next = 34'(ox) * 34'(ox);
        sy_next  = 34'(y_reg) * 34'(y_reg);
        syo_next = 34'(oy) * 34'(oy);
        s_fl = 35'(sx_reg)  + 35'(syo_reg);
        s_fr = 35'(sxo_reg) + 35'(syo_reg);
        s_bl = 35'(sx_reg)  + 35'(sy_reg);
        s_br = 35'(sxo_reg) + 35'(sy_reg);
        half_next[CORNER_FL] = s_fl[33:1];
        half_next[CORNER_FR] = s_fr[33:1];
        half_next[CORNER_BL] = s_bl[33:1];
        half_next[CORNER_BR] = s_br[33:1];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        if (load[1])
        begin
            sx_reg  <= sx_next;
            sxo_reg <= sxo_next;
            sy_reg  <= sy_next;
            syo_reg <= syo_next;
        end
        if (load[2])
        begin
            half_reg <= half_next;
        end
    end

    assign half_sq   = half_reg;
    assign out_valid = valid[NST-1];

endmodule

`default_nettype wire

### hdl/qdp_isqrt.sv
// qdp_isqrt: four-lane pipelined digit-by-digit integer square root.
// Depends on qdp_pkg and qdp_pipe_ctrl.
`default_nettype none

module qdp_isqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qdp_pkg::half_sq_vec_t half_sq,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qdp_pkg::q16_vec_t     dnorm
);
    import qdp_pkg::*;

    localparam int unsigned ITERS = 17;
    localparam int unsigned STEPS = 3;
    localparam int unsigned NST   = (ITERS + STEPS - 1) / STEPS;

    typedef struct packed {
        logic [33:0] rad;
        logic [19:0] rem;
        q16_t        root;
    } sq_lane_t;
    typedef sq_lane_t [LANES-1:0] sq_vec_t;

    logic [NST-1:0] load;
    logic [NST-1:0] valid;

    sq_vec_t st_reg  [NST];
    sq_vec_t st_next [NST];
    sq_vec_t seed;

    function automatic sq_lane_t sqrt_step(input sq_lane_t a);
        sq_lane_t    r;
        logic [19:0] trial;
        logic [19:0] tst;
        r     = a;
        trial = {a.rem[17:0], a.rad[33:32]};
        tst   = {1'b0, a.root, 2'b01};
        r.rad = {a.rad[31:0], 2'b00};
        if (trial >= tst)
        begin
            r.rem  = trial - tst;
            r.root = {a.root[15:0], 1'b1};
        end
        else
        begin
            r.rem  = trial;
            r.root = {a.root[15:0], 1'b0};
        end
        return r;
    endfunction

    function automatic sq_vec_t sqrt_stage(input sq_vec_t a, input int unsigned first);
        sq_vec_t r;
        r = a;
        for (int unsigned j = 0; j < STEPS; j++)
        begin
            if (first + j < ITERS)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    r[l] = sqrt_step(r[l]);
                end
            end
        end
        return r;
    endfunction

    qdp_pipe_ctrl #(.STAGES(NST)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_ready(out_ready),
        .load     (load),
        .valid    (valid)
    );

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            seed[l].rad  = {1'b0, half_sq[l]};
            seed[l].rem  = '0;
            seed[l].root = '0;
        end
        st_next[0] = sqrt_stage(seed, 0);
        for (int unsigned k = 1; k < NST; k++)
        begin
            st_next[k] = sqrt_stage(st_reg[k-1], k * STEPS);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int unsigned k = 0; k < NST; k++)
        begin
            if (load[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            dnorm[l] = st_reg[NST-1][l].root;
        end
    end

    assign out_valid = valid[NST-1];

`ifndef NO_ASSERTIONS
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dnorm[0] <= ONE_Q16) && (dnorm[1] <= ONE_Q16) &&
                      (dnorm[2] <= ONE_Q16) && (dnorm[3] <= ONE_Q16))
        else $error("square root above unit distance");
`endif

endmodule

`default_nettype wire

### hdl/qdp_cos_lerp.sv
// qdp_cos_lerp: cosine table lookup with linear interpolation, four lanes.
// Depends on qdp_pkg and qdp_pipe_ctrl; the table is built at elaboration.
`default_nettype none

module qdp_cos_lerp #(
    parameter int unsigned TABLE_POINTS = qdp_pkg::TABLE_POINTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qdp_pkg::q16_vec_t dnorm,
    output logic              out_valid,
    input  logic              out_ready,
    output qdp_pkg::q16_vec_t gain
);
    import qdp_pkg::*;

    localparam int unsigned NST  = 4;
    localparam int unsigned IDXW = $clog2(TABLE_POINTS);
    localparam int unsigned PW   = 17 + IDXW;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    function automatic q16_t cos_entry(input logic [63:0] theta);
        logic [63:0] t2;
        logic [63:0] term;
        longint      acc;
        t2   = (theta * theta) >> 30;
        term = ONE_Q30;
        acc  = longint'(ONE_Q30);
        for (int k = 1; k <= 8; k++)
        begin
            term = ((term * t2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k[0])
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > longint'(ONE_Q30))
        begin
            acc = longint'(ONE_Q30);
        end
        return 17'((64'(acc) + 64'd8192) >> 14);
    endfunction

    q16_t cos_tab [TABLE_POINTS];

    for (genvar i = 0; i < TABLE_POINTS; i++)
    begin : g_tab
        localparam logic [63:0] THETA = (HALF_PI_Q30 * 64'(i)) / 64'(TABLE_POINTS - 1);
        assign cos_tab[i] = cos_entry(THETA);
    end

    logic [NST-1:0] load;
    logic [NST-1:0] valid;

    logic [LANES-1:0][IDXW-1:0] i0_reg, i0_next, i1_reg, i1_next;
    logic [LANES-1:0][15:0]     f0_reg, f0_next, f1_reg, f1_next;
    logic [LANES-1:0]           l0_reg, l0_next, l1_reg, l1_next, l2_reg, l2_next;
    q16_vec_t                   t0_reg, t0_next, t1_reg, t1_next, tb_reg, tb_next;
    logic [LANES-1:0][33:0]     pa_reg, pa_next, pb_reg, pb_next;
    q16_vec_t                   g_reg, g_next;

    qdp_pipe_ctrl #(.STAGES(NST)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_ready(out_ready),
        .load     (load),
        .valid    (valid)
    );

    always_comb
    begin
        q16_t            dnc;
        logic [PW-1:0]   p;
        logic [IDXW-1:0] ix;
        logic [33:0]     s;
        for (int l = 0; l < LANES; l++)
        begin
            dnc        = (dnorm[l] > ONE_Q16) ? ONE_Q16 : dnorm[l];
            p          = PW'(dnc) * PW'(TABLE_POINTS - 1);
            ix         = p[IDXW+15:16];
            i0_next[l] = ix;
            f0_next[l] = p[15:0];
            l0_next[l] = (ix >= IDXW'(TABLE_POINTS - 1));
            i1_next[l] = l0_next[l] ? ix : IDXW'(ix + 1'b1);

            t0_next[l] = cos_tab[i0_reg[l]];
            t1_next[l] = cos_tab[i1_reg[l]];
            f1_next[l] = f0_reg[l];
            l1_next[l] = l0_reg[l];

            pa_next[l] = 34'(t0_reg[l]) * 34'(ONE_Q16 - {1'b0, f1_reg[l]});
            pb_next[l] = 34'(t1_reg[l]) * 34'(f1_reg[l]);
            tb_next[l] = t0_reg[l];
            l2_next[l] = l1_reg[l];

            s         = pa_reg[l] + pb_reg[l] + 34'd32768;
            g_next[l] = l2_reg[l] ? tb_reg[l] : s[32:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            i0_reg <= i0_next;
            i1_reg <= i1_next;
            f0_reg <= f0_next;
            l0_reg <= l0_next;
        end
        if (load[1])
        begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            f1_reg <= f1_next;
            l1_reg <= l1_next;
        end
        if (load[2])
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            tb_reg <= tb_next;
            l2_reg <= l2_next;
        end
        if (load[3])
        begin
            g_reg <= g_next;
        end
    end

    assign gain      = g_reg;
    assign out_valid = valid[NST-1];

endmodule

`default_nettype wire

### hdl/qdp_norm.sv
// qdp_norm: divides each raw gain by the sum of all four, rounded, via a
// pipelined restoring divider. Depends on qdp_pkg and qdp_pipe_ctrl.
`default_nettype none

module qdp_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qdp_pkg::q16_vec_t raw,
    output logic              out_valid,
    input  logic              out_ready,
    output qdp_pkg::q16_vec_t gain
);
    import qdp_pkg::*;

    localparam int unsigned QBITS = 17;
    localparam int unsigned STEPS = 3;
    localparam int unsigned NDIV  = (QBITS + STEPS - 1) / STEPS;
    localparam int unsigned NST   = NDIV + 2;

    typedef struct packed {
        logic [19:0] rem;
        logic [16:0] bits;
        q16_t        quo;
    } dv_lane_t;
    typedef dv_lane_t [LANES-1:0] dv_vec_t;

    logic [NST-1:0] load;
    logic [NST-1:0] valid;

    logic [LANES-1:0][33:0] num_reg, num_next;
    logic [18:0]            d0_reg, d0_next;
    logic                   z0_reg, z0_next;
    dv_vec_t                dv_reg  [NDIV];
    dv_vec_t                dv_next [NDIV];
    logic [18:0]            d_reg   [NDIV];
    logic [NDIV-1:0]        z_reg;
    dv_vec_t                seed;
    q16_vec_t               gain_reg, gain_next;

    function automatic dv_vec_t div_stage(input dv_vec_t a, input logic [18:0] d,
                                          input int unsigned first);
        dv_vec_t     r;
        logic [19:0] t;
        r = a;
        for (int unsigned j = 0; j < STEPS; j++)
        begin
            if (first + j < QBITS)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    t         = {r[l].rem[18:0], r[l].bits[16]};
                    r[l].bits = {r[l].bits[15:0], 1'b0};
                    if (t >= {1'b0, d})
                    begin
                        r[l].rem = t - {1'b0, d};
                        r[l].quo = {r[l].quo[15:0], 1'b1};
                    end
                    else
                    begin
                        r[l].rem = t;
                        r[l].quo = {r[l].quo[15:0], 1'b0};
                    end
                end
            end
        end
        return r;
    endfunction

    qdp_pipe_ctrl #(.STAGES(NST)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_ready(out_ready),
        .load     (load),
        .valid    (valid)
    );

    always_comb
    begin
        q16_t q;
        d0_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            d0_next = d0_next + 19'(raw[l]);
        end
        z0_next = (d0_next == '0);
        for (int l = 0; l < LANES; l++)
        begin
            num_next[l]  = {1'b0, raw[l], 16'h0000} + 34'(d0_next[18:1]);
            seed[l].rem  = 20'(num_reg[l][33:17]);
            seed[l].bits = num_reg[l][16:0];
            seed[l].quo  = '0;
        end
        dv_next[0] = div_stage(seed, d0_reg, 0);
        for (int unsigned k = 1; k < NDIV; k++)
        begin
            dv_next[k] = div_stage(dv_reg[k-1], d_reg[k-1], k * STEPS);
        end
        for (int l = 0; l < LANES; l++)
        begin
            q = dv_reg[NDIV-1][l].quo;
            if (z_reg[NDIV-1])
            begin
                gain_next[l] = '0;
            end
            else
            begin
                gain_next[l] = (q > ONE_Q16) ? ONE_Q16 : q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            num_reg <= num_next;
            d0_reg  <= d0_next;
            z0_reg  <= z0_next;
        end
        if (load[1])
        begin
            dv_reg[0] <= dv_next[0];
            d_reg[0]  <= d0_reg;
            z_reg[0]  <= z0_reg;
        end
        for (int unsigned k = 1; k < NDIV; k++)
        begin
            if (load[k+1])
            begin
                dv_reg[k] <= dv_next[k];
                d_reg[k]  <= d_reg[k-1];
                z_reg[k]  <= z_reg[k-1];
            end
        end
        if (load[NST-1])
        begin
            gain_reg <= gain_next;
        end
    end

    assign gain      = gain_reg;
    assign out_valid = valid[NST-1];

endmodule

`default_nettype wire
